### hdl/token_bucket_limiter_assert.svh
// Assertion macros shared by the token bucket limiter.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define TOKEN_BUCKET_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tbl_pkg.sv
package tbl_pkg;

	// Field widths.
	localparam int TIME_W = 63;
	localparam int TOK_W  = 32;
	localparam int WAIT_W = 48;
	localparam int DVD_W  = 64;
	localparam int DVS_W  = 32;
	localparam int CNT_W  = $clog2(DVD_W);
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LOAD         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAP          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOKENS_PER_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_NS         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RETRY_NS        = 3'd4;

	// Register reset values.
	localparam logic [TOK_W-1:0] BUCKET_CAP_RST = 32'd1024;
	localparam logic [TOK_W-1:0] TPI_RST        = 32'd1;
	localparam logic [TOK_W-1:0] INTERVAL_RST   = 32'd1000;
	localparam logic [TOK_W-1:0] MIN_RETRY_RST  = 32'd0;

	// Largest reportable wait.
	localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0] now_ns;
		logic [TOK_W-1:0]  request_amount;
	} req_t;

	typedef struct packed {
		logic              granted;
		logic [WAIT_W-1:0] retry_wait_ns;
		logic [TOK_W-1:0]  tokens_left;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic tdiv_start;
		logic tdiv_take;
		logic refill_mul;
		logic refill_add;
		logic decide;
		logic wait_mul;
		logic wdiv_start;
		logic wait_take;
		logic rsp_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic refill_skip;
		logic div_done;
		logic deny;
		logic tpi_zero;
	} dp_stat_t;

endpackage

### hdl/tbl_div.sv
module tbl_div
	import tbl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W-1:0] trial;
	logic             fits;

	// One restoring step: bring in the next dividend bit and try to subtract.
	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign trial   = shifted[DVS_W-1:0] - dvs_q;
	assign fits    = shifted >= {1'b0, dvs_q};

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Partial remainder and quotient bits, which shift into the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial : shifted[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

### hdl/tbl_dp.sv
module tbl_dp
	import tbl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOK_W-1:0]     cfg_data,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output rsp_t                 rsp
);

	logic [TOK_W-1:0]  max_q;
	logic [TOK_W-1:0]  tpi_q;
	logic [TOK_W-1:0]  intv_q;
	logic [TOK_W-1:0]  minr_q;
	logic [TOK_W-1:0]  count_q;
	logic [TIME_W-1:0] last_q;

	logic [TIME_W-1:0] now_q;
	logic [TOK_W-1:0]  want_q;
	logic [TOK_W-1:0]  n_lo_q;
	logic              n_big_q;
	logic [DVD_W-1:0]  product_q;
	logic [TOK_W-1:0]  shortfall_q;
	logic              granted_q;
	logic [WAIT_W-1:0] wait_q;
	rsp_t              rsp_q;

	logic [TIME_W-1:0] elapsed;
	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;
	logic [DVS_W-1:0]  div_rem;
	logic [TOK_W-1:0]  mul_a;
	logic [TOK_W-1:0]  mul_b;
	logic [DVD_W-1:0]  mul_p;
	logic [TOK_W-1:0]  room;
	logic              bucket_full;
	logic [WAIT_W-1:0] quo_wait;

	// Time since the last refill and the cases that refill nothing.
	assign elapsed = now_q - last_q;

	assign stat.refill_skip = (intv_q == '0) || (now_q < last_q);
	assign stat.div_done    = div_done;
	assign stat.deny        = want_q > count_q;
	assign stat.tpi_zero    = tpi_q == '0;

	// The divider serves the elapsed-time division and the retry-wait division.
	assign div_start = cmd.tdiv_start || cmd.wdiv_start;
	assign div_dvd   = cmd.wdiv_start ? product_q : {1'b0, elapsed};
	assign div_dvs   = cmd.wdiv_start ? tpi_q : intv_q;

	tbl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// One shared 32 by 32 multiplier: refill tokens, or shortfall times interval.
	assign mul_a = cmd.wait_mul ? shortfall_q : n_lo_q;
	assign mul_b = cmd.wait_mul ? intv_q : tpi_q;
	assign mul_p = DVD_W'(mul_a) * DVD_W'(mul_b);

	assign room        = max_q - count_q;
	assign bucket_full = (count_q >= max_q) || (tpi_q == '0);

	// Quotient of the wait division, saturated to the field.
	assign quo_wait = (div_quo[DVD_W-1:WAIT_W] != '0) ? WAIT_MAX : div_quo[WAIT_W-1:0];

	// Configuration registers and the bucket state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= BUCKET_CAP_RST;
			tpi_q   <= TPI_RST;
			intv_q  <= INTERVAL_RST;
			minr_q  <= MIN_RETRY_RST;
			count_q <= '0;
			last_q  <= '0;
		end else begin
			if (cmd.tdiv_take) begin
				last_q <= now_q - {{(TIME_W-DVS_W){1'b0}}, div_rem};
			end
			if (cmd.refill_add && !bucket_full) begin
				if (n_big_q || (product_q > {{(DVD_W-TOK_W){1'b0}}, room})) begin
					count_q <= max_q;
				end else begin
					count_q <= count_q + product_q[TOK_W-1:0];
				end
			end
			if (cmd.decide && !stat.deny) begin
				count_q <= count_q - want_q;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BUCKET_LOAD:         count_q <= cfg_data;
					REG_BUCKET_CAP:          max_q   <= cfg_data;
					REG_TOKENS_PER_INTERVAL: tpi_q   <= cfg_data;
					REG_INTERVAL_NS:         intv_q  <= cfg_data;
					REG_MIN_RETRY_NS:        minr_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Working registers of the current request and the result register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q  <= req.now_ns;
			want_q <= req.request_amount;
		end
		if (cmd.tdiv_take) begin
			n_lo_q  <= div_quo[TOK_W-1:0];
			n_big_q <= div_quo[DVD_W-1:TOK_W] != '0;
		end
		if (cmd.refill_mul || cmd.wait_mul) begin
			product_q <= mul_p;
		end
		if (cmd.decide) begin
			granted_q   <= !stat.deny;
			wait_q      <= stat.deny ? WAIT_MAX : '0;
			shortfall_q <= want_q - count_q;
		end
		if (cmd.wait_take) begin
			if (quo_wait < {{(WAIT_W-TOK_W){1'b0}}, minr_q}) begin
				wait_q <= {{(WAIT_W-TOK_W){1'b0}}, minr_q};
			end else begin
				wait_q <= quo_wait;
			end
		end
		if (cmd.rsp_load) begin
			rsp_q.granted       <= granted_q;
			rsp_q.retry_wait_ns <= wait_q;
			rsp_q.tokens_left   <= count_q;
		end
	end

	assign rsp = rsp_q;

endmodule

### hdl/tbl_ctrl.sv
module tbl_ctrl
	import tbl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_REF    = 10'b00_0000_0010,
		ST_TDIV   = 10'b00_0000_0100,
		ST_MUL    = 10'b00_0000_1000,
		ST_ADD    = 10'b00_0001_0000,
		ST_DEC    = 10'b00_0010_0000,
		ST_WMUL   = 10'b00_0100_0000,
		ST_WSTART = 10'b00_1000_0000,
		ST_WDIV   = 10'b01_0000_0000,
		ST_FIN    = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	// The result register can take a new result when empty or being drained.
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// Sequencing of one request through refill, decision and wait computation.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_REF;
				end
			end
			ST_REF: begin
				if (stat.refill_skip) begin
					state_d = ST_DEC;
				end else begin
					cmd.tdiv_start = 1'b1;
					state_d        = ST_TDIV;
				end
			end
			ST_TDIV: begin
				if (stat.div_done) begin
					cmd.tdiv_take = 1'b1;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.refill_mul = 1'b1;
				state_d        = ST_ADD;
			end
			ST_ADD: begin
				cmd.refill_add = 1'b1;
				state_d        = ST_DEC;
			end
			ST_DEC: begin
				cmd.decide = 1'b1;
				state_d    = (stat.deny && !stat.tpi_zero) ? ST_WMUL : ST_FIN;
			end
			ST_WMUL: begin
				cmd.wait_mul = 1'b1;
				state_d      = ST_WSTART;
			end
			ST_WSTART: begin
				cmd.wdiv_start = 1'b1;
				state_d        = ST_WDIV;
			end
			ST_WDIV: begin
				if (stat.div_done) begin
					cmd.wait_take = 1'b1;
					state_d       = ST_FIN;
				end
			end
			ST_FIN: begin
				if (rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

### hdl/token_bucket_limiter.sv
// Token bucket rate limiter. Each request transaction carries a time stamp in
// nanoseconds and a token count; the block refills the bucket by the whole
// intervals elapsed (capped at the bucket limit register), then grants the
// request and takes the tokens, or denies it and reports a retry wait of
// shortfall times interval_ns over tokens_per_interval, at least min_retry_ns
// and saturated to 48 bits. Requests are processed one at a time: a granted
// request uses the shared radix-2 divider once, a denied request with a nonzero
// refill rate uses it twice, and a request whose time stamp moves backward, or
// with interval_ns of zero, skips the refill division.
// The finished result waits in an output register, so the next request is
// accepted while it is still held. Configuration writes are taken at any
// time with no back pressure, but they must only be issued while the block
// is idle; writing the bucket load register sets the token count.
`include "token_bucket_limiter_assert.svh"

module token_bucket_limiter
	import tbl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOK_W-1:0]     cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     cfg_we;

	// A configuration transaction completes every cycle it is offered.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	tbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tbl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

	// Only one request is in flight, and its result never follows at once.
	`TBL_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request taken")
	`TBL_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready, !$rose(rsp_valid), "result too early")
	// A granted request never reports a wait.
	`TBL_ASSERT_NOW(a_grant_no_wait, rsp_valid && rsp.granted, rsp.retry_wait_ns == '0, "grant wait")

endmodule
